[design/mbrptc_pkg.sv]
// Package for the MBR partition table check: field widths, table offsets,
// signature and type codes, result kinds. No dependencies.
package mbrptc_pkg;

    localparam int unsigned DATA_W    = 8;
    localparam int unsigned POS_W     = 13;
    localparam int unsigned SS_W      = 13;
    localparam int unsigned DISK_W    = 48;
    localparam int unsigned START_W   = 32;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SLOT_W    = 2;
    localparam int unsigned SLOTS     = 4;
    localparam int unsigned TBL_WORDS = SLOTS * 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [POS_W-1:0] TABLE_OFFSET = 13'h1BE;
    localparam logic [POS_W-1:0] TABLE_END    = 13'h1FE;
    localparam logic [POS_W-1:0] SIG_LO_POS   = 13'd510;
    localparam logic [POS_W-1:0] SIG_HI_POS   = 13'd511;
    localparam logic [POS_W-1:0] POS_MAX      = 13'h1FFF;
    localparam logic [SS_W-1:0]  STD_SECTOR   = 13'd512;

    localparam logic [15:0]       SIG_VALUE = 16'hAA55;
    localparam logic [DATA_W-1:0] TYPE_GPT  = 8'hEE;
    localparam logic [DATA_W-1:0] TYPE_CD   = 8'hCD;
    localparam int unsigned       BOOT_BIT  = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SECTORS = 1'b1;

    typedef enum logic [1:0] {
        KIND_UNKNOWN  = 2'd0,
        KIND_READ_ERR = 2'd1,
        KIND_WHOLE    = 2'd2,
        KIND_PART     = 2'd3
    } kind_t;

endpackage

[design/mbrptc_if.sv]
// Valid/ready channel interfaces for sector bytes in and verdict items out.
// Depends on mbrptc_pkg.
interface mbrptc_in_if;
    logic                             valid;
    logic                             ready;
    logic [mbrptc_pkg::DATA_W-1:0]    data_byte;
    logic                             read_failed;
    logic                             end_of_sector;

    modport source (output valid, output data_byte, output read_failed,
                    output end_of_sector, input ready);
    modport sink   (input valid, input data_byte, input read_failed,
                    input end_of_sector, output ready);
endinterface

interface mbrptc_out_if;
    logic                             valid;
    logic                             ready;
    mbrptc_pkg::kind_t                kind;
    logic [mbrptc_pkg::SLOT_W-1:0]    slot;
    logic [mbrptc_pkg::START_W-1:0]   first_sector;
    logic [mbrptc_pkg::DISK_W-1:0]    length;
    logic                             last_result;

    modport source (output valid, output kind, output slot, output first_sector,
                    output length, output last_result, input ready);
    modport sink   (input valid, input kind, input slot, input first_sector,
                    input length, input last_result, output ready);
endinterface

[design/mbrptc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbrptc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/mbr_partition_table_check.sv]
// Top level of the MBR partition table check: byte intake, table RAM,
// verdict sequencer and output register. Depends on mbrptc_pkg, mbrptc_if, mbrptc_ram.
//
// Channel    Dir  Handshake     Carries
// in_item    in   valid/ready   data_byte, read_failed, end_of_sector
// out_item   out  valid/ready   kind, slot, first_sector, length, last_result
// cfg        in   cfg_we only   cfg_idx selects sector_size (0) or disk_sectors (1)
//
// Flow: bytes stream one per cycle while the sequencer is idle. A verdict that
// is settled without the table passes through the S_ONE state into the output
// register, waiting there while the output register is still full. A verdict
// that walks the table reads all 16 table words through the table RAM's single
// read port, evaluates the table and then emits one result per used slot.
// Reset: async, active low; control and configuration reset at once, the
// sector size to 512; the table RAM is never cleared (a verdict reads it only
// after a full sector). Stalls: bytes keep flowing while a result waits in the
// output register; a stalled output holds the sequencer in S_ONE or its emit state.
module mbr_partition_table_check #(
    parameter int unsigned MAX_SECTOR_BYTES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mbrptc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [mbrptc_pkg::DISK_W-1:0]    cfg_data,
    mbrptc_in_if.sink                        in_item,
    mbrptc_out_if.source                     out_item
);
    import mbrptc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE,
        S_READ,
        S_EVAL,
        S_EMIT
    } state_t;

    localparam int unsigned ADDR_W = $clog2(TBL_WORDS);

    // configuration
    logic [SS_W-1:0]    sector_size_reg;
    logic [DISK_W-1:0]  disk_sectors_reg;

    // intake state
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [15:0]        sig_reg;
    logic [15:0]        sig_next;
    logic               err_reg;
    logic               err_next;
    logic [23:0]        asm_reg;

    // sequencer
    state_t             state_reg;
    kind_t              pend_kind_reg;
    logic [ADDR_W:0]    cnt_reg;
    logic               cap_vld_reg;
    logic [ADDR_W-1:0]  cap_idx_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  last_slot_reg;
    logic [SLOTS-1:0]   used_reg;

    // table working copy
    logic [SLOTS-1:0]   flag_reg;
    logic [DATA_W-1:0]  type_reg;
    logic [START_W-1:0] start_reg [SLOTS];
    logic [START_W-1:0] len_reg   [SLOTS];
    logic [SLOTS-1:0]   ovf_reg;

    // output register
    logic               out_vld_reg;
    kind_t              out_kind_reg;
    logic [SLOT_W-1:0]  out_slot_reg;
    logic [START_W-1:0] out_first_reg;
    logic [DISK_W-1:0]  out_len_reg;
    logic               out_last_reg;

    logic               in_fire;
    logic               in_table;
    logic [POS_W-1:0]   tbl_diff;
    logic [5:0]         tbl_off;
    logic [POS_W-1:0]   count;
    logic               ss_bad;
    logic               ram_we;
    logic               ram_re;
    logic [WORD_W-1:0]  ram_rdata;
    logic [SLOT_W-1:0]  cap_e;
    logic [1:0]         cap_k;
    logic [SLOT_W-1:0]  sel_slot;
    logic [START_W-1:0] sel_start;
    logic [32:0]        bound_sum;
    logic               bound_ovf;
    logic [SLOTS-1:0]   used_now;
    logic [SLOTS-1:0]   active_now;
    logic               table_ok;
    logic [SLOT_W-1:0]  last_now;
    logic               out_free;
    logic               out_load;

    assign in_item.ready = (state_reg == S_IDLE);
    assign in_fire       = in_item.valid && in_item.ready;

    // byte intake
    assign in_table = (pos_reg >= TABLE_OFFSET) && (pos_reg < TABLE_END);
    assign tbl_diff = pos_reg - TABLE_OFFSET;
    assign tbl_off  = tbl_diff[5:0];
    assign count    = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 13'd1;
    assign err_next = err_reg | in_item.read_failed;
    assign pos_next = in_item.end_of_sector ? '0 : count;

    always_comb
    begin
        sig_next = sig_reg;
        if (pos_reg == SIG_LO_POS)
        begin
            sig_next = {sig_reg[15:8], in_item.data_byte};
        end
        else if (pos_reg == SIG_HI_POS)
        begin
            sig_next = {in_item.data_byte, sig_reg[7:0]};
        end
    end

    assign ss_bad = (sector_size_reg < STD_SECTOR)
                 || (sector_size_reg > SS_W'(MAX_SECTOR_BYTES));

    // table words are little-endian groups of four bytes
    assign ram_we = in_fire && in_table && (tbl_off[1:0] == 2'd3);
    assign ram_re = (state_reg == S_READ) && !cnt_reg[ADDR_W];

    mbrptc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TBL_WORDS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tbl_off[5:2]),
        .wdata ({in_item.data_byte, asm_reg}),
        .re    (ram_re),
        .raddr (cnt_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // capture: word 0 holds the boot flag, word 1 the type, 2 start, 3 count
    assign cap_e     = cap_idx_reg[ADDR_W-1:2];
    assign cap_k     = cap_idx_reg[1:0];
    assign sel_slot  = (state_reg == S_EMIT) ? slot_reg : cap_e;
    assign sel_start = start_reg[sel_slot];
    assign bound_sum = {1'b0, ram_rdata} + {1'b0, sel_start};
    assign bound_ovf = {15'd0, bound_sum} > disk_sectors_reg;

    // evaluate
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            used_now[i] = (start_reg[i] != '0);
        end
        active_now = used_now & flag_reg;
        table_ok = !(|(used_now & ovf_reg))
                && ($countones(active_now) <= 1)
                && (|used_now)
                && (type_reg != TYPE_GPT)
                && !((sector_size_reg != STD_SECTOR) && (type_reg == TYPE_CD));
        last_now = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (used_now[i])
            begin
                last_now = SLOT_W'(i);
            end
        end
    end

    assign out_free = !out_vld_reg || out_item.ready;
    // a new item enters the output register this cycle
    assign out_load = out_free && ((state_reg == S_ONE)
                   || ((state_reg == S_EMIT) && used_reg[slot_reg]));

    // control, configuration and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sector_size_reg  <= STD_SECTOR;
            disk_sectors_reg <= '0;
            pos_reg          <= '0;
            sig_reg          <= '0;
            err_reg          <= 1'b0;
            state_reg        <= S_IDLE;
            pend_kind_reg    <= KIND_UNKNOWN;
            cnt_reg          <= '0;
            cap_vld_reg      <= 1'b0;
            cap_idx_reg      <= '0;
            slot_reg         <= '0;
            last_slot_reg    <= '0;
            used_reg         <= '0;
            out_vld_reg      <= 1'b0;
            out_kind_reg     <= KIND_UNKNOWN;
            out_slot_reg     <= '0;
            out_first_reg    <= '0;
            out_len_reg      <= '0;
            out_last_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_SECTOR_SIZE:  sector_size_reg  <= cfg_data[SS_W-1:0];
                    CFG_DISK_SECTORS: disk_sectors_reg <= cfg_data;
                    default:          ;
                endcase
            end

            if (out_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_item.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            cap_vld_reg <= ram_re;
            cap_idx_reg <= cnt_reg[ADDR_W-1:0];

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        pos_reg <= pos_next;
                        sig_reg <= in_item.end_of_sector ? 16'd0 : sig_next;
                        err_reg <= in_item.end_of_sector ? 1'b0 : err_next;
                        if (in_item.end_of_sector)
                        begin
                            cnt_reg <= '0;
                            priority if (ss_bad)
                            begin
                                pend_kind_reg <= KIND_UNKNOWN;
                                state_reg     <= S_ONE;
                            end
                            else if (err_next)
                            begin
                                pend_kind_reg <= KIND_READ_ERR;
                                state_reg     <= S_ONE;
                            end
                            else if ((count != sector_size_reg) || (sig_next != SIG_VALUE))
                            begin
                                pend_kind_reg <= KIND_UNKNOWN;
                                state_reg     <= S_ONE;
                            end
                            else
                            begin
                                state_reg <= S_READ;
                            end
                        end
                    end
                end
                S_ONE:
                begin
                    if (out_free)
                    begin
                        out_kind_reg  <= pend_kind_reg;
                        out_slot_reg  <= '0;
                        out_first_reg <= '0;
                        out_len_reg   <= (pend_kind_reg == KIND_WHOLE) ? disk_sectors_reg : '0;
                        out_last_reg  <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (ram_re)
                    begin
                        cnt_reg <= cnt_reg + (ADDR_W+1)'(1);
                    end
                    if (cap_vld_reg && (cap_idx_reg == ADDR_W'(TBL_WORDS - 1)))
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    used_reg      <= used_now;
                    last_slot_reg <= last_now;
                    slot_reg      <= '0;
                    if (table_ok)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        pend_kind_reg <= KIND_WHOLE;
                        state_reg     <= S_ONE;
                    end
                end
                S_EMIT:
                begin
                    if (!used_reg[slot_reg])
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                    else if (out_free)
                    begin
                        out_kind_reg  <= KIND_PART;
                        out_slot_reg  <= slot_reg;
                        out_first_reg <= sel_start;
                        out_len_reg   <= {16'd0, len_reg[slot_reg]};
                        out_last_reg  <= (slot_reg == last_slot_reg);
                        slot_reg      <= slot_reg + SLOT_W'(1);
                        if (slot_reg == last_slot_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers: byte assembly and table working copy
    always_ff @(posedge clk)
    begin
        if (in_fire && in_table)
        begin
            unique case (tbl_off[1:0])
                2'd0:    asm_reg[7:0]   <= in_item.data_byte;
                2'd1:    asm_reg[15:8]  <= in_item.data_byte;
                2'd2:    asm_reg[23:16] <= in_item.data_byte;
                default: ;
            endcase
        end
        if (cap_vld_reg)
        begin
            unique case (cap_k)
                2'd0:
                begin
                    flag_reg[cap_e] <= ram_rdata[BOOT_BIT];
                end
                2'd1:
                begin
                    if (cap_e == '0)
                    begin
                        type_reg <= ram_rdata[DATA_W-1:0];
                    end
                end
                2'd2:
                begin
                    start_reg[cap_e] <= ram_rdata;
                end
                default:
                begin
                    len_reg[cap_e] <= ram_rdata;
                    ovf_reg[cap_e] <= bound_ovf;
                end
            endcase
        end
    end

    assign out_item.valid        = out_vld_reg;
    assign out_item.kind         = out_kind_reg;
    assign out_item.slot         = out_slot_reg;
    assign out_item.first_sector = out_first_reg;
    assign out_item.length       = out_len_reg;
    assign out_item.last_result  = out_last_reg;

endmodule

[sim/mbr_verdict_checker.sv]
`timescale 1ns / 100ps
// Verdict checker for the MBR partition table check: tracks the register writes,
// predicts the results of every accepted sector byte and compares each result.
// Depends on mbrptc_pkg and the channel interfaces in mbrptc_if.
module mbr_verdict_checker #(
    parameter int unsigned MAX_SECTOR_BYTES = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mbrptc_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [mbrptc_pkg::DISK_W-1:0]    cfg_data,
    mbrptc_in_if                             bytes_in,
    mbrptc_out_if                            verdicts_out,
    output int                               outstanding,
    output int                               errors
);
    import mbrptc_pkg::*;

    localparam int REPORT_CAP = 30;

    typedef struct {
        kind_t               kind;
        logic [SLOT_W-1:0]   slot;
        logic [START_W-1:0]  first;
        logic [DISK_W-1:0]   len;
        logic                last;
    } verdict_t;

    verdict_t          pending_verdicts[$];

    // shadow of the block's registers and sector state
    logic [SS_W-1:0]   ss_reg;
    logic [DISK_W-1:0] drive_reg;
    logic [POS_W-1:0]  byte_pos;
    logic [7:0]        tbl [TBL_WORDS*4];
    logic [15:0]       sig_reg;
    logic              read_fault;

    initial errors = 0;

    function automatic logic [31:0] entry_word(input int off);
        return {tbl[off+3], tbl[off+2], tbl[off+1], tbl[off]};
    endfunction

    task automatic push_verdict(input kind_t k, input logic [SLOT_W-1:0] s,
                                input logic [START_W-1:0] f,
                                input logic [DISK_W-1:0] l, input logic lst);
        verdict_t v;
        v.kind  = k;
        v.slot  = s;
        v.first = f;
        v.len   = l;
        v.last  = lst;
        pending_verdicts.push_back(v);
    endtask

    task automatic judge_sector(input logic [POS_W-1:0] count);
        logic [31:0] st;
        logic [31:0] ln;
        logic [32:0] span;
        int          active;
        int          used;
        int          lastslot;
        bit          ok;
        active   = 0;
        used     = 0;
        lastslot = 0;
        ok       = 1'b1;
        if (ss_reg < STD_SECTOR || ss_reg > MAX_SECTOR_BYTES)
            push_verdict(KIND_UNKNOWN, '0, '0, '0, 1'b1);
        else if (read_fault)
            push_verdict(KIND_READ_ERR, '0, '0, '0, 1'b1);
        else if (count != ss_reg || sig_reg != SIG_VALUE)
            push_verdict(KIND_UNKNOWN, '0, '0, '0, 1'b1);
        else
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                st = entry_word(s*16 + 8);
                ln = entry_word(s*16 + 12);
                if (st == 0)
                    continue;
                if (tbl[s*16][BOOT_BIT])
                    active++;
                // 33-bit sum, no wrap
                span = {1'b0, st} + {1'b0, ln};
                if (span > drive_reg)
                begin
                    ok = 1'b0;
                    break;
                end
                used++;
                lastslot = s;
            end
            if (ss_reg != STD_SECTOR && tbl[4] == TYPE_CD)
                ok = 1'b0;
            if (tbl[4] == TYPE_GPT)
                ok = 1'b0;
            if (used == 0 || active > 1)
                ok = 1'b0;
            if (!ok)
                push_verdict(KIND_WHOLE, '0, '0, drive_reg, 1'b1);
            else
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    st = entry_word(s*16 + 8);
                    ln = entry_word(s*16 + 12);
                    if (st != 0)
                        push_verdict(KIND_PART, SLOT_W'(s), st, DISK_W'(ln), s == lastslot);
                end
            end
        end
    endtask

    task automatic predict_byte(input logic [7:0] d, input logic rf, input logic eos);
        logic [POS_W-1:0] count;
        if (rf)
            read_fault = 1'b1;
        if (byte_pos >= TABLE_OFFSET && byte_pos < TABLE_END)
            tbl[int'(byte_pos - TABLE_OFFSET)] = d;
        else if (byte_pos == SIG_LO_POS)
            sig_reg[7:0] = d;
        else if (byte_pos == SIG_HI_POS)
            sig_reg[15:8] = d;
        count = (byte_pos < POS_MAX) ? byte_pos + POS_W'(1) : POS_MAX;
        if (!eos)
            byte_pos = count;
        else
        begin
            judge_sector(count);
            byte_pos   = '0;
            sig_reg    = '0;
            read_fault = 1'b0;
        end
    endtask

    function automatic bit field_ok(input string name, input logic [47:0] want,
                                    input logic [47:0] got);
        if (want === got)
            return 1'b1;
        if (errors < REPORT_CAP)
            $display("%0t checker: %s expected %0h, got %0h", $time, name, want, got);
        return 1'b0;
    endfunction

    task automatic compare_result();
        verdict_t want;
        bit       ok;
        if (pending_verdicts.size() == 0)
        begin
            if (errors < REPORT_CAP)
                $display({"%0t checker: expected no result, ",
                          "got kind %0d slot %0d first %0h length %0h"},
                         $time, verdicts_out.kind, verdicts_out.slot,
                         verdicts_out.first_sector, verdicts_out.length);
            errors++;
        end
        else
        begin
            want = pending_verdicts.pop_front();
            ok = field_ok("kind", 48'(want.kind), 48'(verdicts_out.kind))
               & field_ok("slot", 48'(want.slot), 48'(verdicts_out.slot))
               & field_ok("first_sector", 48'(want.first), 48'(verdicts_out.first_sector))
               & field_ok("length", want.len, verdicts_out.length)
               & field_ok("last_result", 48'(want.last), 48'(verdicts_out.last_result));
            if (!ok)
                errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ss_reg     = STD_SECTOR;
            drive_reg  = '0;
            byte_pos   = '0;
            sig_reg    = '0;
            read_fault = 1'b0;
            foreach (tbl[k])
                tbl[k] = '0;
            pending_verdicts.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == CFG_SECTOR_SIZE)
                    ss_reg = cfg_data[SS_W-1:0];
                else if (cfg_idx == CFG_DISK_SECTORS)
                    drive_reg = cfg_data;
            end
            if (bytes_in.valid && bytes_in.ready)
                predict_byte(bytes_in.data_byte, bytes_in.read_failed, bytes_in.end_of_sector);
            if (verdicts_out.valid && verdicts_out.ready)
                compare_result();
            outstanding <= pending_verdicts.size();
        end
    end

endmodule

[sim/mbr_partition_table_check_tb.sv]
`timescale 1ns / 100ps
// Testbench top for mbr_partition_table_check: drives sector bytes and register
// writes, applies back-pressure, and reports the verdict of mbr_verdict_checker.
// Depends on mbrptc_pkg, mbrptc_if, the block itself and mbr_verdict_checker.
module mbr_partition_table_check_tb;
    import mbrptc_pkg::*;

    localparam int MAX_BYTES      = 4096;
    localparam int NO_FAIL        = -1;
    localparam int LONG_HOLD      = 300;   // cycles the sink holds off once
    localparam int DRAIN_CYCLES   = 40;    // margin for the sequencer to finish its verdict walk
    localparam int RANDOM_SECTORS = 70;
    // Roughly 60k bytes are sent, each at worst after the longest sender
    // gap, plus verdict walks and sink stalls. Take about three times that.
    localparam int LIMIT          = 4_000_000;

    localparam logic [7:0] BOOT_FLAG = 8'(1 << BOOT_BIT);
    localparam logic [7:0] TYPE_FAT  = 8'h0C;    // ordinary data partition
    localparam logic [DISK_W-1:0] DISK_MAX = {DISK_W{1'b1}};

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [DISK_W-1:0]    cfg_data;
    logic                 hold_req;     // asks the sink for its one long hold-off
    bit                   burst;        // current sector goes out with no gaps
    int                   outstanding;
    int                   fails;

    // first 512 bytes of the sector being sent; bytes past that are random
    logic [7:0]           image [512];
    logic [SS_W-1:0]      cur_ss;
    logic [DISK_W-1:0]    cur_ds;

    mbrptc_in_if  in_ch ();
    mbrptc_out_if out_ch ();

    mbr_partition_table_check #(
        .MAX_SECTOR_BYTES (MAX_BYTES)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .in_item  (in_ch),
        .out_item (out_ch)
    );

    mbr_verdict_checker #(
        .MAX_SECTOR_BYTES (MAX_BYTES)
    ) u_verdict_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .bytes_in     (in_ch),
        .verdicts_out (out_ch),
        .outstanding  (outstanding),
        .errors       (fails)
    );

    always #2 clk = ~clk;

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 20);
    endfunction

    // One item on the byte channel; returns at the edge that accepts it,
    // with valid still high so the next item can follow back to back.
    task automatic send_byte(input logic [7:0] d, input logic rf, input logic eos);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.data_byte     <= d;
        in_ch.read_failed   <= rf;
        in_ch.end_of_sector <= eos;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // n bytes, the last one flagged end_of_sector; read_failed on byte fail_at.
    task automatic send_sector(input int n, input int fail_at);
        burst = ($urandom_range(0, 2) == 0);
        for (int k = 0; k < n; k++)
            send_byte(k < 512 ? image[k] : 8'($urandom), k == fail_at, k == n - 1);
    endtask

    // Sender pause: drop valid, wait for every verdict, then let the
    // sequencer finish its walk before anything else happens.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Both registers, back to back, only with the block idle.
    task automatic program_regs(input logic [SS_W-1:0] ss, input logic [DISK_W-1:0] ds);
        settle();
        cur_ss = ss;
        cur_ds = ds;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SECTOR_SIZE;
        cfg_data <= DISK_W'(ss);
        @(posedge clk);
        cfg_idx  <= CFG_DISK_SECTORS;
        cfg_data <= ds;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_entry(input int slot, input logic [7:0] flag, input logic [7:0] ptype,
                             input logic [31:0] start, input logic [31:0] count);
        int base;
        base = int'(TABLE_OFFSET) + slot*16;
        image[base]   = flag;
        image[base+4] = ptype;
        for (int k = 0; k < 4; k++)
        begin
            image[base+8+k]  = start[8*k +: 8];
            image[base+12+k] = count[8*k +: 8];
        end
    endtask

    // Random boot code, every slot unused (start 0, rest random), entry 0 an
    // ordinary type, good signature.
    task automatic fresh_image();
        foreach (image[k])
            image[k] = 8'($urandom);
        for (int s = 0; s < SLOTS; s++)
            for (int k = 8; k < 12; k++)
                image[int'(TABLE_OFFSET) + s*16 + k] = 8'h00;
        image[int'(TABLE_OFFSET) + 4] = TYPE_FAT;
        image[SIG_LO_POS] = SIG_VALUE[7:0];
        image[SIG_HI_POS] = SIG_VALUE[15:8];
    endtask

    // Random table that mostly fits the drive, so most sectors reach the
    // per-entry results; some entries overrun, some flags and types reject.
    task automatic random_table();
        logic [63:0] cap;
        logic [31:0] st;
        logic [31:0] ln;
        logic [7:0]  fl;
        logic [7:0]  ty;
        int          r;
        fresh_image();
        cap = (cur_ds > 48'hFFFF_FFFF) ? 64'hFFFF_FFFF : 64'(cur_ds);
        for (int s = 0; s < SLOTS; s++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                if (cap >= 4 && $urandom_range(0, 9) < 8)
                begin
                    st = 32'(1 + ($urandom % (cap / 2)));
                    ln = 32'($urandom % (cap / 2));
                end
                else
                begin
                    st = $urandom;
                    if (st == 0)
                        st = 32'hFFFF_FFFF;
                    ln = $urandom;
                end
                fl = ($urandom_range(0, 3) == 0) ? BOOT_FLAG : 8'($urandom_range(0, 127));
                r  = $urandom_range(0, 19);
                ty = (r == 0) ? TYPE_GPT : (r == 1) ? TYPE_CD : 8'($urandom);
                set_entry(s, fl, ty, st, ln);
            end
        end
    endtask

    // Mostly full well-formed sectors; the rest break one rule.
    task automatic random_sector();
        int len;
        int fail_at;
        int r;
        random_table();
        fail_at = NO_FAIL;
        len = (cur_ss >= 512 && cur_ss <= MAX_BYTES) ? int'(cur_ss) : $urandom_range(1, 600);
        r = $urandom_range(0, 99);
        if (r < 8)
            fail_at = $urandom_range(0, len - 1);
        else if (r < 16 && len > 1)
            len = $urandom_range(1, len - 1);
        else if (r < 21)
            len = len + $urandom_range(1, 20);
        else if (r < 26)
            image[$urandom_range(510, 511)] ^= 8'(1 << $urandom_range(0, 7));
        send_sector(len, fail_at);
    endtask

    // Result sink: random stalls in stretches that are switched on and off,
    // plus one long hold-off on request so verdicts back up into the input.
    initial
    begin : result_sink
        int stall_left;
        int hold_left;
        int quiet_left;
        bit stalls_on;
        bit hold_used;
        stall_left   = 0;
        hold_left    = 0;
        quiet_left   = 0;
        stalls_on    = 1'b1;
        hold_used    = 1'b0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet_left == 0)
            begin
                stalls_on  = ($urandom_range(0, 3) != 0);
                quiet_left = $urandom_range(200, 800);
            end
            quiet_left--;
            if (hold_req && !hold_used)
            begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    initial
    begin : watchdog
        repeat (LIMIT) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int ss_pick;
        int ds_pick;
        int sectors;
        logic [SS_W-1:0]   ss;
        logic [DISK_W-1:0] ds;
        in_ch.valid         = 1'b0;
        in_ch.data_byte     = '0;
        in_ch.read_failed   = 1'b0;
        in_ch.end_of_sector = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = CFG_SECTOR_SIZE;
        cfg_data = '0;
        hold_req = 1'b0;
        burst    = 1'b0;
        sectors  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: 512-byte sectors on a drive of one million sectors
        program_regs(STD_SECTOR, 48'd1_000_000);

        // single bootable partition
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_FAT, 32'd2048, 32'd100_000);
        send_sector(512, NO_FAIL);

        // all four slots used, one active; slot 3 ends exactly at the drive end
        fresh_image();
        set_entry(0, 8'h00, TYPE_FAT, 32'd63, 32'd900);
        set_entry(1, BOOT_FLAG, TYPE_FAT, 32'd1000, 32'd4000);
        set_entry(2, 8'h7F, TYPE_FAT, 32'd5000, 32'd100_000);
        set_entry(3, 8'h00, TYPE_FAT, 32'd900_000, 32'd100_000);
        send_sector(512, NO_FAIL);

        // only the last slot used
        fresh_image();
        set_entry(3, BOOT_FLAG, TYPE_FAT, 32'd1, 32'd999_999);
        send_sector(512, NO_FAIL);

        // slot 2 runs one sector past the drive end: whole drive
        fresh_image();
        set_entry(0, 8'h00, TYPE_FAT, 32'd1, 32'd10);
        set_entry(2, 8'h00, TYPE_FAT, 32'd999_999, 32'd2);
        send_sector(512, NO_FAIL);

        // empty table: whole drive
        fresh_image();
        send_sector(512, NO_FAIL);

        // two active entries: whole drive
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_FAT, 32'd100, 32'd10);
        set_entry(1, 8'hFF, TYPE_FAT, 32'd200, 32'd10);
        send_sector(512, NO_FAIL);

        // protective GPT entry: whole drive
        fresh_image();
        set_entry(0, 8'h00, TYPE_GPT, 32'd1, 32'd999_999);
        send_sector(512, NO_FAIL);

        // hybrid CD entry is fine on 512-byte sectors
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_CD, 32'd16, 32'd5000);
        send_sector(512, NO_FAIL);

        // signature with one bad byte, then with its bytes swapped
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_FAT, 32'd2048, 32'd100);
        image[SIG_HI_POS] = 8'hAB;
        send_sector(512, NO_FAIL);
        image[SIG_LO_POS] = SIG_VALUE[15:8];
        image[SIG_HI_POS] = SIG_VALUE[7:0];
        send_sector(512, NO_FAIL);

        // read failure on the first byte and on the final byte
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_FAT, 32'd2048, 32'd100);
        send_sector(512, 0);
        send_sector(512, 511);

        // sector ends early, ends late
        send_sector(1, NO_FAIL);
        send_sector(300, NO_FAIL);
        send_sector(513, NO_FAIL);

        // 8192 + 512 bytes: a count that wrapped would land on 512, the
        // saturated count does not
        send_sector(8704, NO_FAIL);

        // sector size zero: not recognized even with a read failure
        program_regs('0, '0);
        send_sector(1, 0);

        // one below the minimum
        program_regs(13'd511, DISK_MAX);
        fresh_image();
        send_sector(511, 5);

        // 1024-byte sectors, largest drive: all-ones start and length still fit
        // within the drive with the full 33-bit sum
        program_regs(13'd1024, DISK_MAX);
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_FAT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        set_entry(1, 8'h00, TYPE_FAT, 32'd1, 32'd0);
        send_sector(1024, NO_FAIL);
        // hybrid CD entry on a non-512 sector: whole drive
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_CD, 32'd16, 32'd5000);
        send_sector(1024, NO_FAIL);

        // sum just past a 32-bit drive size; a wrapping sum would pass it
        program_regs(STD_SECTOR, 48'hFFFF_FFFF);
        fresh_image();
        set_entry(0, BOOT_FLAG, TYPE_FAT, 32'hFFFF_FFFF, 32'd1);
        send_sector(512, NO_FAIL);

        // empty drive: every used entry overruns
        program_regs(STD_SECTOR, '0);
        fresh_image();
        set_entry(0, 8'h00, TYPE_FAT, 32'd1, 32'd0);
        send_sector(512, NO_FAIL);

        // largest supported sector
        program_regs(13'd4096, DISK_MAX);
        fresh_image();
        set_entry(1, BOOT_FLAG, TYPE_FAT, 32'd2048, 32'h0010_0000);
        set_entry(2, 8'h00, TYPE_FAT, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sector(4096, NO_FAIL);

        // above the supported maximum, top of the field
        program_regs({SS_W{1'b1}}, DISK_MAX);
        send_sector(1, NO_FAIL);

        // ---- back-pressure: sink holds off while short sectors keep coming,
        // so verdicts pile up and the byte channel has to stall
        program_regs(STD_SECTOR, 48'd1_000_000);
        hold_req <= 1'b1;
        repeat (12) send_sector(1, NO_FAIL);

        // ---- random phases: new registers, a handful of sectors, drain
        while (sectors < RANDOM_SECTORS)
        begin
            ss_pick = $urandom_range(0, 19);
            if (ss_pick < 12)
                ss = STD_SECTOR;
            else if (ss_pick < 14)
                ss = 13'd1024;
            else if (ss_pick < 15)
                ss = 13'd4096;
            else if (ss_pick < 17)
                ss = SS_W'($urandom_range(0, 511));
            else if (ss_pick < 18)
                ss = SS_W'($urandom_range(4097, 8191));
            else
                ss = SS_W'($urandom_range(513, 1023));
            ds_pick = $urandom_range(0, 9);
            if (ds_pick == 0)
                ds = '0;
            else if (ds_pick == 1)
                ds = DISK_MAX;
            else if (ds_pick < 5)
                ds = DISK_W'($urandom);
            else if (ds_pick < 7)
                ds = DISK_W'({$urandom, $urandom});
            else
                ds = DISK_W'($urandom_range(1000, 50_000_000));
            program_regs(ss, ds);
            repeat ((ss > 13'd1024) ? 1 : $urandom_range(3, 8))
            begin
                random_sector();
                sectors++;
            end
        end

        settle();
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
